/* design/fdc_pkg.sv */
// Shared types, codes and decode tables for the floppy controller head stepper.
package fdc_pkg;

   // Controller steps run once this many ticks have added up.
   localparam int unsigned TICKS_PER_STEP = 20;

   // Request kinds.
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;
   localparam logic [1:0] KIND_NOP   = 2'd3;

   // Register offsets.
   localparam logic [1:0] SEL_STATUS = 2'd0;
   localparam logic [1:0] SEL_TRACK  = 2'd1;
   localparam logic [1:0] SEL_SECTOR = 2'd2;
   localparam logic [1:0] SEL_DATA   = 2'd3;

   // Controller phases.
   localparam logic [1:0] PH_INACTIVE  = 2'd0;
   localparam logic [1:0] PH_STARTING  = 2'd1;
   localparam logic [1:0] PH_EXECUTING = 2'd2;
   localparam logic [1:0] PH_ENDING    = 2'd3;

   // Status bits.
   localparam logic [7:0] ST_BUSY   = 8'h01;
   localparam logic [7:0] ST_DREQ   = 8'h02;
   localparam logic [7:0] ST_TRK_NZ = 8'h04;
   localparam logic [7:0] ST_SPUN   = 8'h20;
   localparam logic [7:0] ST_MOTOR  = 8'h80;

   // Force-interrupt command recognition.
   localparam logic [7:0] FORCE_MASK = 8'hf0;
   localparam logic [7:0] FORCE_CODE = 8'hd0;

   localparam logic [7:0] RESTORE_TRACK = 8'd80;

   // Operations.
   localparam logic [3:0] OP_RESTORE  = 4'd0;
   localparam logic [3:0] OP_SEEK     = 4'd1;
   localparam logic [3:0] OP_STEP     = 4'd2;
   localparam logic [3:0] OP_STEP_IN  = 4'd3;
   localparam logic [3:0] OP_STEP_OUT = 4'd4;
   localparam logic [3:0] OP_SECT_RD  = 4'd5;
   localparam logic [3:0] OP_SECT_WR  = 4'd6;
   localparam logic [3:0] OP_ADDR_RD  = 4'd7;
   localparam logic [3:0] OP_FORCE    = 4'd8;
   localparam logic [3:0] OP_TRK_RD   = 4'd9;
   localparam logic [3:0] OP_TRK_WR   = 4'd10;

   // Command types.
   localparam logic [2:0] TYPE_STEPPING = 3'd1;
   localparam logic [2:0] TYPE_SECTOR   = 3'd2;
   localparam logic [2:0] TYPE_OTHER    = 3'd3;
   localparam logic [2:0] TYPE_FORCE    = 3'd4;

   typedef struct packed {
      logic [1:0] cmd;
      logic [1:0] reg_offset;
      logic [7:0] write_data;
      logic [7:0] tick_count;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_line;
      logic       busy_flag;
   } rsp_type;

   typedef struct packed {
      logic [1:0] phase;
      logic [7:0] tick_accum;
      logic [7:0] command_reg;
      logic [3:0] operation;
      logic [2:0] op_type;
      logic [7:0] track_reg;
      logic [7:0] sector_reg;
      logic [7:0] data_reg;
      logic [7:0] target_track;
      logic [7:0] status_reg;
      logic       step_direction;
      logic       irq_pending;
   } state_type;

   function automatic logic [3:0] op_of_nibble(input logic [3:0] nib);
      logic [3:0] op;
      case (nib)
         4'h0: op = OP_RESTORE;
         4'h1: op = OP_SEEK;
         4'h2, 4'h3: op = OP_STEP;
         4'h4, 4'h5: op = OP_STEP_IN;
         4'h6, 4'h7: op = OP_STEP_OUT;
         4'h8, 4'h9: op = OP_SECT_RD;
         4'ha, 4'hb: op = OP_SECT_WR;
         4'hc: op = OP_ADDR_RD;
         4'hd: op = OP_FORCE;
         4'he: op = OP_TRK_RD;
         default: op = OP_TRK_WR;
      endcase
      return op;
   endfunction

   function automatic logic [2:0] type_of_nibble(input logic [3:0] nib);
      logic [2:0] ty;
      case (nib) inside
         [4'h0:4'h7]: ty = TYPE_STEPPING;
         [4'h8:4'hb]: ty = TYPE_SECTOR;
         4'hd:        ty = TYPE_FORCE;
         default:     ty = TYPE_OTHER;
      endcase
      return ty;
   endfunction

endpackage

/* design/fdc_if.sv */
// Request and response channel interfaces of the head stepper unit.
interface fdc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [1:0] reg_offset;
   logic [7:0] write_data;
   logic [7:0] tick_count;

   modport source (output valid, cmd, reg_offset, write_data, tick_count, input ready);
   modport sink (input valid, cmd, reg_offset, write_data, tick_count, output ready);
endinterface

interface fdc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       irq_line;
   logic       busy_flag;

   modport source (output valid, read_data, irq_line, busy_flag, input ready);
   modport sink (input valid, read_data, irq_line, busy_flag, output ready);
endinterface

/* design/fdc_core.sv */
// Next-state and response logic for one request of the head stepper.
module fdc_core
   import fdc_pkg::*;
(
   input  state_type cur_state,
   input  req_type   item,
   output state_type next_state,
   output rsp_type   result
);

   logic [8:0] tick_sum;
   logic       do_step;
   logic [3:0] nib;
   logic [7:0] rd;
   logic       dir;
   logic       move;

   always_comb begin
      next_state = cur_state;
      rd = 8'd0;
      nib = cur_state.command_reg[7:4];
      tick_sum = {1'b0, cur_state.tick_accum} + {1'b0, item.tick_count};
      do_step = 1'b0;
      dir = cur_state.step_direction;
      move = 1'b0;

      case (item.cmd)
         KIND_READ: begin
            case (item.reg_offset)
               SEL_STATUS: begin
                  next_state.irq_pending = 1'b0;
                  rd = cur_state.status_reg;
               end
               SEL_TRACK:  rd = cur_state.track_reg;
               SEL_SECTOR: rd = cur_state.sector_reg;
               default: begin
                  next_state.status_reg = cur_state.status_reg & ~ST_DREQ;
                  rd = cur_state.data_reg;
               end
            endcase
         end
         KIND_WRITE: begin
            if ((cur_state.status_reg & ST_BUSY) != 8'd0) begin
               // Only a force interrupt gets through while a command runs.
               if (item.reg_offset == SEL_STATUS &&
                   (item.write_data & FORCE_MASK) == FORCE_CODE) begin
                  next_state.phase = PH_ENDING;
               end
            end else begin
               case (item.reg_offset)
                  SEL_STATUS: begin
                     next_state.command_reg = item.write_data;
                     next_state.irq_pending = 1'b0;
                     next_state.phase = PH_STARTING;
                  end
                  SEL_TRACK:  next_state.track_reg = item.write_data;
                  SEL_SECTOR: next_state.sector_reg = item.write_data;
                  default:    next_state.data_reg = item.write_data;
               endcase
            end
         end
         KIND_TICK: begin
            if (tick_sum >= 9'(TICKS_PER_STEP)) begin
               next_state.tick_accum = 8'd0;
               do_step = 1'b1;
            end else begin
               next_state.tick_accum = tick_sum[7:0];
            end
         end
         default: ;
      endcase

      if (do_step) begin
         case (cur_state.phase)
            PH_STARTING: begin
               next_state.operation = op_of_nibble(nib);
               next_state.op_type = type_of_nibble(nib);
               case (op_of_nibble(nib))
                  OP_RESTORE: begin
                     next_state.track_reg = RESTORE_TRACK;
                     next_state.target_track = 8'd0;
                  end
                  OP_SEEK:     next_state.target_track = cur_state.data_reg;
                  OP_STEP_IN:  next_state.step_direction = 1'b1;
                  OP_STEP_OUT: next_state.step_direction = 1'b0;
                  default: ;
               endcase
               next_state.status_reg = cur_state.status_reg | ST_BUSY;
               next_state.phase = PH_EXECUTING;
            end
            PH_EXECUTING: begin
               if (cur_state.op_type == TYPE_STEPPING) begin
                  next_state.status_reg = cur_state.status_reg | ST_SPUN | ST_MOTOR;
                  if (cur_state.operation == OP_RESTORE || cur_state.operation == OP_SEEK) begin
                     if (cur_state.track_reg == cur_state.target_track) begin
                        next_state.phase = PH_ENDING;
                     end else begin
                        dir = cur_state.track_reg < cur_state.target_track;
                        move = 1'b1;
                     end
                  end else begin
                     move = 1'b1;
                     next_state.phase = PH_ENDING;
                  end
                  next_state.step_direction = dir;
                  if (move) begin
                     // Outward stops at track zero; inward wraps like the register.
                     if (dir) begin
                        next_state.track_reg = cur_state.track_reg + 8'd1;
                     end else if (cur_state.track_reg != 8'd0) begin
                        next_state.track_reg = cur_state.track_reg - 8'd1;
                     end
                  end
                  if (next_state.track_reg != 8'd0) begin
                     next_state.status_reg = next_state.status_reg | ST_TRK_NZ;
                  end else begin
                     next_state.status_reg = next_state.status_reg & ~ST_TRK_NZ;
                  end
               end
            end
            PH_ENDING: begin
               next_state.phase = PH_INACTIVE;
               next_state.status_reg = cur_state.status_reg & ~ST_BUSY;
               next_state.irq_pending = 1'b1;
            end
            default: ;
         endcase
      end

      result.read_data = rd;
      result.irq_line = next_state.irq_pending;
      result.busy_flag = next_state.status_reg[0];
   end

endmodule

/* design/floppy_controller_head_stepper_unit.sv */
// Top level of the floppy controller head stepper: request stage, state and response register.
// Each request (bus read, bus write or tick) is captured in an input register and handled from
// there when the response register can advance; the controller state and the response register
// are updated together. One request is taken per clock while the input stage is empty or can
// advance, and its response waits in the response register until taken; the response register
// lets a new request enter while an earlier response still waits. A step of the controller
// runs on the tick that brings the accumulated count to 20 or more.
module floppy_controller_head_stepper_unit
   import fdc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   fdc_req_if.sink    req_ch,
   fdc_rsp_if.source  rsp_ch
);

   logic      stage_valid_ff;
   logic      stage_valid_in;
   req_type   stage_item_ff;
   req_type   req_item;
   state_type state_ff;
   state_type state_in;
   rsp_type   rsp_ff;
   rsp_type   core_rsp;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      advance;
   logic      work;
   logic      req_fire;

   assign req_item.cmd = req_ch.cmd;
   assign req_item.reg_offset = req_ch.reg_offset;
   assign req_item.write_data = req_ch.write_data;
   assign req_item.tick_count = req_ch.tick_count;

   assign advance = !rsp_valid_ff || rsp_ch.ready;
   assign work = stage_valid_ff && advance;
   assign req_ch.ready = !stage_valid_ff || advance;
   assign req_fire = req_ch.valid && req_ch.ready;

   assign stage_valid_in = req_fire ? 1'b1 : (work ? 1'b0 : stage_valid_ff);
   assign rsp_valid_in = work ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   fdc_core u_core (
      .cur_state  (state_ff),
      .item       (stage_item_ff),
      .next_state (state_in),
      .result     (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (work) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_item_ff <= req_item;
      end
      if (work) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.read_data = rsp_ff.read_data;
   assign rsp_ch.irq_line = rsp_ff.irq_line;
   assign rsp_ch.busy_flag = rsp_ff.busy_flag;

   // Busy is set exactly while a command executes or is ending.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.status_reg[0] == (state_ff.phase == PH_EXECUTING || state_ff.phase == PH_ENDING))
      else $error("busy bit disagrees with controller phase");

   // The accumulator is cleared whenever it reaches a step.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.tick_accum < 8'(TICKS_PER_STEP))
      else $error("tick accumulator reached the step count");

   // A status read always leaves the interrupt low in its response.
   assert property (@(posedge clock) disable iff (reset)
      work && stage_item_ff.cmd == KIND_READ && stage_item_ff.reg_offset == SEL_STATUS
      |=> !rsp_ff.irq_line)
      else $error("status read did not clear the interrupt");

   // The response busy flag matches the updated state written together with it.
   assert property (@(posedge clock) disable iff (reset)
      work |=> rsp_ff.busy_flag == state_ff.status_reg[0])
      else $error("response busy flag differs from state");

   // A stalled request stays in the input stage unchanged.
   assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !advance |=> stage_valid_ff && $stable(stage_item_ff))
      else $error("stalled request was lost or changed");

endmodule
